// File: design/bglph_pkg.sv
// Shared constants, register codes and controller/datapath interface types.
`timescale 1ns / 1ps
`default_nettype none

package bglph_pkg;

  localparam int DOT_COUNT_DEF = 32;

  localparam int IDX_W      = 5;
  localparam int COLOR_W    = 2;
  localparam int LEVEL_W    = 8;
  localparam int BREAK_W    = 6;
  localparam int FADE_W     = 16;
  localparam int TIME_W     = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [COLOR_W-1:0] COL_BLACK  = 2'd0;
  localparam logic [COLOR_W-1:0] COL_GREEN  = 2'd1;
  localparam logic [COLOR_W-1:0] COL_ORANGE = 2'd2;
  localparam logic [COLOR_W-1:0] COL_RED    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_BREAK_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BREAK_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FADE_TIME  = 2'd2;

  localparam logic [BREAK_W-1:0] BREAK_LOW_RST  = 6'd18;
  localparam logic [BREAK_W-1:0] BREAK_HIGH_RST = 6'd28;
  localparam logic [FADE_W-1:0]  FADE_TIME_RST  = 16'd3000;

  // controller -> datapath
  typedef struct packed {
    logic load;       // latch clamped level
    logic tick;       // advance ms counter
    logic walk_init;  // walk pointer starts at bar top
    logic rise_step;  // emit one painted dot
    logic fall_step;  // emit one blacked dot
    logic peak_step;  // emit the peak frame
    logic last;       // final frame of this input
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic lvl_gt_bar;
    logic lvl_lt_bar;
    logic walk_at_lvl;
    logic peak_due;
    logic out_free;
  } stat_t;

  // one displayed frame, dot_valid in the lowest bit
  typedef struct packed {
    logic                last;
    logic [IDX_W-1:0]    peak_index;
    logic                peak_paint;
    logic [COLOR_W-1:0]  dot_color;
    logic [IDX_W-1:0]    dot_index;
    logic                dot_valid;
  } frame_t;

endpackage

`default_nettype wire

// File: design/bglph_ctrl.sv
// Sequencer for bar animation and peak frames.
`timescale 1ns / 1ps
`default_nettype none

module bglph_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           s_tvalid,
  input  wire logic           func,
  output logic                s_tready,
  input  wire bglph_pkg::stat_t stat,
  output bglph_pkg::cmd_t     cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DECIDE = 3'd1;
  localparam logic [2:0] ST_RISE   = 3'd2;
  localparam logic [2:0] ST_FALL   = 3'd3;
  localparam logic [2:0] ST_PEAK   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          if (func) begin
            cmd.load   = 1'b1;
            state_next = ST_DECIDE;
          end else begin
            cmd.tick = 1'b1;
          end
        end
      end
      ST_DECIDE: begin
        cmd.walk_init = 1'b1;
        if (stat.lvl_gt_bar) begin
          state_next = ST_RISE;
        end else if (stat.lvl_lt_bar) begin
          state_next = ST_FALL;
        end else if (stat.peak_due) begin
          state_next = ST_PEAK;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_RISE, ST_FALL: begin
        if (stat.out_free) begin
          cmd.rise_step = (state == ST_RISE);
          cmd.fall_step = (state == ST_FALL);
          cmd.last      = stat.walk_at_lvl && !stat.peak_due;
          if (stat.walk_at_lvl) begin
            state_next = stat.peak_due ? ST_PEAK : ST_IDLE;
          end
        end
      end
      ST_PEAK: begin
        if (stat.out_free) begin
          cmd.peak_step = 1'b1;
          cmd.last      = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// File: design/bglph_dp.sv
// Datapath: config registers, bar/peak state, ms timer and the output frame register.
`timescale 1ns / 1ps
`default_nettype none

module bglph_dp #(
  parameter int DOT_COUNT = bglph_pkg::DOT_COUNT_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_valid,
  input  wire logic [bglph_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [bglph_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic [bglph_pkg::LEVEL_W-1:0]      new_level,
  input  wire bglph_pkg::cmd_t                    cmd,
  output bglph_pkg::stat_t                        stat,
  input  wire logic                               m_tready,
  output logic                                    m_tvalid,
  output bglph_pkg::frame_t                       frame
);

  localparam int PW = (DOT_COUNT > 1) ? $clog2(DOT_COUNT) : 1;
  localparam int CW = (PW > bglph_pkg::BREAK_W) ? PW : bglph_pkg::BREAK_W;
  localparam logic [bglph_pkg::LEVEL_W:0] LVL_MAX = (bglph_pkg::LEVEL_W + 1)'(DOT_COUNT - 1);
  localparam logic [PW-1:0] TOP_DOT = PW'(DOT_COUNT - 1);

  logic [bglph_pkg::BREAK_W-1:0] break_low;
  logic [bglph_pkg::BREAK_W-1:0] break_high;
  logic [bglph_pkg::FADE_W-1:0]  fade_time_ms;
  logic [PW-1:0]                 bar_top;
  logic [PW-1:0]                 peak_pos;
  logic [PW-1:0]                 walk_dot;
  logic [PW-1:0]                 lvl;
  logic [bglph_pkg::TIME_W-1:0]  now_ms;
  logic [bglph_pkg::TIME_W-1:0]  last_decay_ms;

  logic [PW-1:0]                   lvl_next;
  logic [bglph_pkg::LEVEL_W:0]     lvl_mag;
  logic [bglph_pkg::TIME_W-1:0]    elapsed;
  logic                            fade_over;
  logic                            peak_jump;
  logic                            peak_above_bar;
  logic [bglph_pkg::COLOR_W-1:0]   walk_color;
  logic                            emit;
  bglph_pkg::frame_t               frame_next;

  // saturate the signed request to 0..DOT_COUNT-1
  assign lvl_mag = {2'b00, new_level[bglph_pkg::LEVEL_W-2:0]};
  always_comb begin
    if (new_level[bglph_pkg::LEVEL_W-1]) begin
      lvl_next = '0;
    end else if (lvl_mag > LVL_MAX) begin
      lvl_next = TOP_DOT;
    end else begin
      lvl_next = PW'(lvl_mag);
    end
  end

  assign elapsed        = now_ms - last_decay_ms;
  assign fade_over      = elapsed > {{(bglph_pkg::TIME_W - bglph_pkg::FADE_W){1'b0}}, fade_time_ms};
  assign peak_jump      = (lvl >= peak_pos);
  assign peak_above_bar = (peak_pos > bar_top);

  always_comb begin
    if (CW'(walk_dot) < CW'(break_low)) begin
      walk_color = bglph_pkg::COL_GREEN;
    end else if (CW'(walk_dot) < CW'(break_high)) begin
      walk_color = bglph_pkg::COL_ORANGE;
    end else begin
      walk_color = bglph_pkg::COL_RED;
    end
  end

  assign stat.lvl_gt_bar  = (lvl > bar_top);
  assign stat.lvl_lt_bar  = (lvl < bar_top);
  assign stat.walk_at_lvl = (walk_dot == lvl);
  assign stat.peak_due    = peak_jump || fade_over;
  assign stat.out_free    = !m_tvalid || m_tready;

  assign emit = cmd.rise_step || cmd.fall_step || cmd.peak_step;

  always_comb begin
    frame_next      = '0;
    frame_next.last = cmd.last;
    if (cmd.rise_step) begin
      frame_next.dot_valid  = 1'b1;
      frame_next.dot_index  = bglph_pkg::IDX_W'(walk_dot);
      frame_next.dot_color  = walk_color;
      frame_next.peak_index = bglph_pkg::IDX_W'(peak_pos);
    end else if (cmd.fall_step) begin
      frame_next.dot_valid  = 1'b1;
      frame_next.dot_index  = bglph_pkg::IDX_W'(walk_dot);
      frame_next.dot_color  = bglph_pkg::COL_BLACK;
      frame_next.peak_paint = 1'b1;
      frame_next.peak_index = bglph_pkg::IDX_W'(peak_pos);
    end else begin
      frame_next.peak_paint = 1'b1;
      if (peak_jump) begin
        frame_next.peak_index = bglph_pkg::IDX_W'(lvl);
      end else if (peak_above_bar) begin
        // decay: black out the old peak dot, paint one lower
        frame_next.dot_valid  = 1'b1;
        frame_next.dot_index  = bglph_pkg::IDX_W'(peak_pos);
        frame_next.dot_color  = bglph_pkg::COL_BLACK;
        frame_next.peak_index = bglph_pkg::IDX_W'(peak_pos - 1'b1);
      end else begin
        frame_next.peak_index = bglph_pkg::IDX_W'(peak_pos);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      break_low    <= bglph_pkg::BREAK_LOW_RST;
      break_high   <= bglph_pkg::BREAK_HIGH_RST;
      fade_time_ms <= bglph_pkg::FADE_TIME_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        bglph_pkg::REG_BREAK_LOW:  break_low    <= cfg_data[bglph_pkg::BREAK_W-1:0];
        bglph_pkg::REG_BREAK_HIGH: break_high   <= cfg_data[bglph_pkg::BREAK_W-1:0];
        bglph_pkg::REG_FADE_TIME:  fade_time_ms <= cfg_data[bglph_pkg::FADE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bar_top       <= '0;
      peak_pos      <= '0;
      walk_dot      <= '0;
      lvl           <= '0;
      now_ms        <= '0;
      last_decay_ms <= '0;
    end else begin
      if (cmd.tick) begin
        now_ms <= now_ms + 1'b1;
      end
      if (cmd.load) begin
        lvl <= lvl_next;
      end
      if (cmd.walk_init) begin
        walk_dot <= bar_top;
      end
      if (cmd.rise_step || cmd.fall_step) begin
        if (stat.walk_at_lvl) begin
          bar_top <= lvl;
        end else if (cmd.rise_step) begin
          walk_dot <= walk_dot + 1'b1;
        end else begin
          walk_dot <= walk_dot - 1'b1;
        end
      end
      if (cmd.peak_step) begin
        if (peak_jump) begin
          peak_pos <= lvl;
        end else begin
          last_decay_ms <= now_ms;
          if (peak_above_bar) begin
            peak_pos <= peak_pos - 1'b1;
          end
        end
      end
    end
  end

  // output word register; frees up as soon as the sink takes the word
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      frame <= frame_next;
    end
  end

endmodule

`default_nettype wire

// File: design/bargraph_level_peak_hold.sv
// Top level: bargraph level meter with peak-hold dot.
//
// Input stream (s_*): one word per item. s_tuser[0] selects the kind:
// 0 is a one-millisecond tick, 1 a level sample in s_tdata[7:0] (signed,
// saturated to 0..DOT_COUNT-1). Ticks are taken while idle and give no word.
// Output stream (m_*): one word per displayed frame; m_tlast marks the final
// frame caused by a level sample. A sample may give no frame at all.
// A level sample gives N frames (at most DOT_COUNT+1): the walk counter
// moves the bar one dot per frame, then a single peak frame may follow.
// s_tready is high only while the sequencer is idle; it may be high while the
// last frame still sits in the output register.
// When the sink stalls, the frame holds in the output register and the
// sequencer waits. Config writes (cfg_*) are always accepted and must only
// be issued while idle.
// Reset clears bar, peak, timer and output valid, and loads break points
// 18 and 28 and a fade time of 3000 ms.
`timescale 1ns / 1ps
`default_nettype none

module bargraph_level_peak_hold #(
  parameter int DOT_COUNT = bglph_pkg::DOT_COUNT_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [bglph_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bglph_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [7:0]                       s_tdata,   // [7:0] new_level
  input  wire logic [0:0]                       s_tuser,   // [0] func
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // [0] dot_valid, [5:1] dot_index, [7:6] dot_color, [8] peak_paint,
  // [13:9] peak_index, [15:14] zero
  output logic [15:0]                           m_tdata,
  output logic                                  m_tlast
);

  bglph_pkg::cmd_t   cmd;
  bglph_pkg::stat_t  stat;
  bglph_pkg::frame_t frame;

  assign cfg_ready = 1'b1;

  bglph_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .func     (s_tuser[0]),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bglph_dp #(
    .DOT_COUNT (DOT_COUNT)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .new_level (s_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .frame     (frame)
  );

  assign m_tdata = {2'b00, frame.peak_index, frame.peak_paint, frame.dot_color,
                    frame.dot_index, frame.dot_valid};
  assign m_tlast = frame.last;

endmodule

`default_nettype wire

// File: design/bglph_chk.sv
// Port-level checker for the bargraph meter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module bglph_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [15:0] m_tdata,
  input wire logic        m_tlast
);

  // a stalled output word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output word changed while stalled");

  // a frame without a dot write is a peak-only frame with zeroed dot fields
  a_peak_only: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[8] && (m_tdata[7:1] == 7'd0))
    else $error("peak-only frame malformed");

  // a painted dot without peak repaint comes from the rising walk: never black
  a_rise_color: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] && !m_tdata[8] |-> (m_tdata[7:6] != 2'd0))
    else $error("rising frame painted black");

  // no output word straight out of reset
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

  // no input word is taken while a non-final frame of an earlier sample is pending
  a_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !s_tready)
    else $error("input taken mid-sequence");

endmodule

bind bargraph_level_peak_hold bglph_chk u_bglph_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

`default_nettype wire

// File: test/bargraph_frame_checker.sv
// Frame checker for the bargraph meter: predicts each displayed frame and compares it.
`timescale 1ns / 1ps

package bglph_tb_pkg;
  // input word kinds carried on s_tuser
  localparam logic FUNC_TICK  = 1'b0;
  localparam logic FUNC_LEVEL = 1'b1;
endpackage

module bargraph_frame_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [bglph_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bglph_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                             s_tvalid,
  input  logic                             s_tready,
  input  logic [7:0]                       s_tdata,   // [7:0] new_level
  input  logic [0:0]                       s_tuser,   // [0] func
  input  logic                             m_tvalid,
  input  logic                             m_tready,
  // [0] dot_valid, [5:1] dot_index, [7:6] dot_color, [8] peak_paint,
  // [13:9] peak_index, [15:14] zero
  input  logic [15:0]                      m_tdata,
  input  logic                             m_tlast,
  output int                               pending,
  output int                               errors
);
  import bglph_pkg::*;
  import bglph_tb_pkg::*;

  logic [BREAK_W-1:0] orange_from;
  logic [BREAK_W-1:0] red_from;
  logic [FADE_W-1:0]  hold_ms;
  logic [IDX_W-1:0]   bar_lvl;
  logic [IDX_W-1:0]   peak_dot;
  logic [TIME_W-1:0]  ms_now;
  logic [TIME_W-1:0]  ms_decayed;

  frame_t frames_due[$];
  frame_t seen;
  frame_t want;
  int     queued = 0;
  int     fail_count = 0;
  int     frame_no = 0;

  assign pending = queued;
  assign errors  = fail_count;

  task automatic report(input string what, input int got, input int wanted);
    fail_count++;
    $display("%0t: frame %0d: %s is %0d, expected %0d", $time, frame_no, what, got, wanted);
  endtask

  function automatic logic [COLOR_W-1:0] shade_of(input int dot);
    if (dot < orange_from) return COL_GREEN;
    if (dot < red_from) return COL_ORANGE;
    return COL_RED;
  endfunction

  function automatic frame_t make_frame(input logic dv, input int dot,
                                        input logic [COLOR_W-1:0] color,
                                        input logic pp, input logic [IDX_W-1:0] pk);
    frame_t f;
    f.dot_valid  = dv;
    f.dot_index  = dot[IDX_W-1:0];
    f.dot_color  = color;
    f.peak_paint = pp;
    f.peak_index = pk;
    f.last       = 1'b0;
    return f;
  endfunction

  // frames caused by one level word, in display order
  task automatic predict_level(input logic [7:0] raw);
    frame_t           batch[$];
    frame_t           f;
    int               lvl;
    logic [IDX_W-1:0] old_peak;
    lvl = $signed(raw);
    if (lvl < 0) lvl = 0;
    else if (lvl > DOT_COUNT_DEF - 1) lvl = DOT_COUNT_DEF - 1;

    if (lvl > bar_lvl) begin
      for (int d = bar_lvl; d <= lvl; d++)
        batch.push_back(make_frame(1'b1, d, shade_of(d), 1'b0, peak_dot));
    end else if (lvl < bar_lvl) begin
      for (int d = bar_lvl; d >= lvl; d--)
        batch.push_back(make_frame(1'b1, d, COL_BLACK, 1'b1, peak_dot));
    end
    bar_lvl = lvl[IDX_W-1:0];

    if (lvl >= peak_dot) begin
      peak_dot = lvl[IDX_W-1:0];
      batch.push_back(make_frame(1'b0, 0, COL_BLACK, 1'b1, peak_dot));
    end else if (ms_now - ms_decayed > hold_ms) begin
      // elapsed time taken modulo 2^32
      ms_decayed = ms_now;
      if (peak_dot > bar_lvl) begin
        old_peak = peak_dot;
        peak_dot = peak_dot - 1'b1;
        batch.push_back(make_frame(1'b1, old_peak, COL_BLACK, 1'b1, peak_dot));
      end else begin
        batch.push_back(make_frame(1'b0, 0, COL_BLACK, 1'b1, peak_dot));
      end
    end

    foreach (batch[i]) begin
      f = batch[i];
      f.last = (i == batch.size() - 1);
      frames_due.push_back(f);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      orange_from = BREAK_LOW_RST;
      red_from    = BREAK_HIGH_RST;
      hold_ms     = FADE_TIME_RST;
      bar_lvl     = '0;
      peak_dot    = '0;
      ms_now      = '0;
      ms_decayed  = '0;
      frames_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BREAK_LOW:  orange_from = cfg_data[BREAK_W-1:0];
          REG_BREAK_HIGH: red_from    = cfg_data[BREAK_W-1:0];
          REG_FADE_TIME:  hold_ms     = cfg_data[FADE_W-1:0];
          default: ;
        endcase
      end

      // a word leaving now belongs to an earlier input, so check before predicting
      if (m_tvalid && m_tready) begin
        seen = frame_t'({m_tlast, m_tdata[13:0]});
        if (frames_due.size() == 0) begin
          report("unexpected word, data", m_tdata, 0);
        end else begin
          want = frames_due.pop_front();
          if (seen.dot_valid !== want.dot_valid)
            report("dot_valid", seen.dot_valid, want.dot_valid);
          if (seen.dot_index !== want.dot_index)
            report("dot_index", seen.dot_index, want.dot_index);
          if (seen.dot_color !== want.dot_color)
            report("dot_color", seen.dot_color, want.dot_color);
          if (seen.peak_paint !== want.peak_paint)
            report("peak_paint", seen.peak_paint, want.peak_paint);
          if (seen.peak_index !== want.peak_index)
            report("peak_index", seen.peak_index, want.peak_index);
          if (seen.last !== want.last)
            report("tlast", seen.last, want.last);
          if (m_tdata[15:14] !== 2'b00)
            report("pad bits", m_tdata[15:14], 0);
        end
        frame_no++;
      end

      if (s_tvalid && s_tready) begin
        if (s_tuser[0] == FUNC_TICK) ms_now = ms_now + 1'b1;
        else predict_level(s_tdata);
      end
    end
    queued <= frames_due.size();
  end

endmodule

// File: test/tb_top.sv
// Top of the bargraph meter bench: clock, reset, stimulus, sink and verdict.
`timescale 1ns / 1ps

module tb_top;
  import bglph_pkg::*;
  import bglph_tb_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES  = 400;

  // saturating and sign-boundary level values
  localparam logic [7:0] RAIL_LEVELS [6] = '{8'h80, 8'hFF, 8'h00, 8'd31, 8'd32, 8'h7F};

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata = '0;
  logic [0:0]            s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [15:0]           m_tdata;
  logic                  m_tlast;

  int pending;
  int errors;
  int cycles = 0;
  int holds_asked = 0;
  int holds_done = 0;
  int hold_left = 0;
  bit steady = 1'b0;

  always #4 clk = ~clk;

  bargraph_level_peak_hold dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  bargraph_frame_checker frame_chk (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .pending(pending), .errors(errors)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // sink: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_asked != holds_done) begin
      holds_done <= holds_asked;
      hold_left  <= HOLD_CYCLES;
      m_tready   <= 1'b0;
    end else begin
      m_tready <= steady || ($urandom_range(0, 99) >= 31);
    end
  end

  // valid stays up from one word to the next unless a gap is taken
  task automatic send_item(input logic func, input logic [7:0] lvl);
    while (!steady && $urandom_range(0, 99) < 31) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= lvl;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // a level word with no frame may still be in flight
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(input logic [BREAK_W-1:0] lo, input logic [BREAK_W-1:0] hi,
                            input logic [FADE_W-1:0] fade);
    logic [CFG_DATA_W-1:0] vals [3];
    logic [CFG_IDX_W-1:0]  regs [3];
    vals = '{CFG_DATA_W'(lo), CFG_DATA_W'(hi), fade};
    regs = '{REG_BREAK_LOW, REG_BREAK_HIGH, REG_FADE_TIME};
    cfg_valid <= 1'b1;
    for (int i = 0; i < 3; i++) begin
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic random_run(input int count);
    int pick;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        // burst of ticks so the hold time can run out
        repeat ($urandom_range(1, 8)) send_item(FUNC_TICK, 8'($urandom));
      end else if (pick < 80) begin
        send_item(FUNC_LEVEL, 8'($urandom_range(0, 31)));
      end else if (pick < 90) begin
        send_item(FUNC_LEVEL, RAIL_LEVELS[$urandom_range(0, 5)]);
      end else begin
        send_item(FUNC_LEVEL, 8'($urandom));
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset break points and hold time
    send_item(FUNC_LEVEL, 8'd0);
    send_item(FUNC_LEVEL, 8'h7F);   // full rise plus peak
    send_item(FUNC_LEVEL, 8'h7F);   // peak frame only
    send_item(FUNC_LEVEL, 8'h80);   // full fall, hold not elapsed
    send_item(FUNC_TICK, 8'hFF);
    send_item(FUNC_LEVEL, 8'h80);   // nothing changes
    send_item(FUNC_LEVEL, 8'd32);
    send_item(FUNC_LEVEL, 8'hFF);
    send_item(FUNC_LEVEL, 8'd17);
    send_item(FUNC_LEVEL, 8'd18);
    send_item(FUNC_LEVEL, 8'd27);
    send_item(FUNC_LEVEL, 8'd28);
    send_item(FUNC_LEVEL, 8'h55);
    random_run(25);
    settle();

    // all green, decay after any tick
    write_regs(6'd32, 6'd32, 16'd0);
    send_item(FUNC_LEVEL, 8'd31);
    send_item(FUNC_LEVEL, 8'd10);
    send_item(FUNC_TICK, 8'h00);
    send_item(FUNC_LEVEL, 8'd10);   // peak decay frame
    send_item(FUNC_LEVEL, 8'd10);   // no time passed
    random_run(25);
    settle();

    // all red, peak never decays, no idling on either side
    steady <= 1'b1;
    write_regs(6'd0, 6'd0, 16'hFFFF);
    random_run(25);
    settle();
    steady <= 1'b0;

    // crossed break points
    write_regs(6'd20, 6'd6, 16'd5);
    random_run(25);
    settle();

    write_regs(6'd10, 6'd25, 16'd1);
    random_run(10);
    holds_asked <= holds_asked + 1;
    steady <= 1'b1;
    random_run(15);
    steady <= 1'b0;
    random_run(10);
    settle();

    if (errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// File: files.f
design/bglph_pkg.sv
design/bglph_ctrl.sv
design/bglph_dp.sv
design/bargraph_level_peak_hold.sv
design/bglph_chk.sv
test/bargraph_frame_checker.sv
test/tb_top.sv
